// ===== rtl/utf8cp_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8cp_pkg
// Shared types, constants and the code point to Windows-1251 mapping.
// ----------------------------------------------------------------------------
package utf8cp_pkg;

   localparam int          QDEPTH      = 4;
   localparam int          QPTR_W      = $clog2(QDEPTH);
   localparam logic [7:0]  QMARK       = 8'h3F;
   localparam logic [7:0]  MAX_RESET   = 8'd128;
   localparam logic [20:0] CP_ASCII_HI = 21'h00007F;
   localparam logic [20:0] CP_CYR_LO   = 21'h000410;
   localparam logic [20:0] CP_CYR_HI   = 21'h00044F;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [7:0]  CYR_OFFSET  = 8'h50;     // low byte of 0x410 - 0xC0
   localparam logic [7:0]  SPECIAL_BASE = 8'h80;

   // code points of Windows-1251 bytes 0x80..0xBF, zero where unassigned
   localparam logic [15:0] SPECIAL_CP [64] = '{
      16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
      16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
      16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
      16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
      16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
   };

   // one pending result: a character (by code point) or the end item
   typedef struct packed {
      logic        is_end;
      logic [20:0] cp;
      logic [7:0]  count;
   } res_type;

   // queue entry: one or two results caused by one input byte
   typedef struct packed {
      res_type r0;
      res_type r1;
      logic    two;
   } entry_type;

   function automatic logic [7:0] map_cp(input logic [20:0] cp);
      logic [7:0] res;
      logic       found;
      res   = QMARK;
      found = 1'b0;
      if (cp <= CP_ASCII_HI) begin
         res = cp[7:0];
      end else if (cp >= CP_CYR_LO && cp <= CP_CYR_HI) begin
         res = cp[7:0] - CYR_OFFSET;
      end else begin
         for (int i = 0; i < 64; i++) begin
            if (!found && SPECIAL_CP[i] != 16'h0000 && cp == {5'b0, SPECIAL_CP[i]}) begin
               res   = SPECIAL_BASE + 8'(i);
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/utf8cp_front.sv =====
// ----------------------------------------------------------------------------
// utf8cp_front
// UTF-8 decoder: tracks the open sequence and the per-string count, and
// turns each accepted byte into zero, one or two pending results.
// ----------------------------------------------------------------------------
module utf8cp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  csr_we,
   input  logic [7:0]            csr_data,
   output logic                  push,
   output utf8cp_pkg::entry_type push_data
);
   import utf8cp_pkg::*;

   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  len_ff, len_in;
   logic [20:0] acc_ff, acc_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  max_ff, max_in;

   res_type     a_res, b_res;
   logic        a_valid, b_valid;
   logic [20:0] acc_next;
   logic        fresh, cp_ok;

   // decode one byte
   always_comb begin
      pend_in  = pend_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      a_res    = '0;
      b_res    = '0;
      fresh    = 1'b1;
      acc_next = {acc_ff[14:0], in_byte[5:0]};
      cp_ok    = 1'b0;
      unique case (len_ff)
         2'd1:    cp_ok = acc_next >= 21'h80;
         2'd2:    cp_ok = acc_next >= 21'h800 &&
                          (acc_next < 21'hD800 || acc_next > 21'hDFFF);
         2'd3:    cp_ok = acc_next >= 21'h10000 && acc_next <= CP_MAX;
         default: cp_ok = 1'b0;
      endcase

      // continue or break the open sequence
      if (pend_ff != 2'd0) begin
         if (in_byte[7:6] == 2'b10) begin
            fresh   = 1'b0;
            acc_in  = acc_next;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               a_res.cp = cp_ok ? acc_next : {13'b0, QMARK};
               if (cnt_ff < max_ff) begin
                  a_valid = 1'b1;
                  cnt_in  = cnt_ff + 8'd1;
               end
               len_in = 2'd0;
               acc_in = '0;
            end
         end else begin
            a_res.cp = {13'b0, QMARK};
            if (cnt_ff < max_ff) begin
               a_valid = 1'b1;
               cnt_in  = cnt_ff + 8'd1;
            end
            pend_in = 2'd0;
            len_in  = 2'd0;
            acc_in  = '0;
         end
      end

      // byte taken afresh
      if (fresh) begin
         if (in_byte == 8'h00) begin
            b_valid      = 1'b1;
            b_res.is_end = 1'b1;
            b_res.count  = cnt_in;
            pend_in      = 2'd0;
            len_in       = 2'd0;
            acc_in       = '0;
            cnt_in       = 8'd0;
         end else if (in_byte < 8'h80 || in_byte < 8'hC2 || in_byte > 8'hF4) begin
            b_res.cp = (in_byte < 8'h80) ? {13'b0, in_byte} : {13'b0, QMARK};
            if (cnt_in < max_ff) begin
               b_valid = 1'b1;
               cnt_in  = cnt_in + 8'd1;
            end
         end else if (in_byte <= 8'hDF) begin
            pend_in = 2'd1;
            len_in  = 2'd1;
            acc_in  = {16'b0, in_byte[4:0]};
         end else if (in_byte <= 8'hEF) begin
            pend_in = 2'd2;
            len_in  = 2'd2;
            acc_in  = {17'b0, in_byte[3:0]};
         end else begin
            pend_in = 2'd3;
            len_in  = 2'd3;
            acc_in  = {18'b0, in_byte[2:0]};
         end
      end

      if (!accept) begin
         pend_in = pend_ff;
         len_in  = len_ff;
         acc_in  = acc_ff;
         cnt_in  = cnt_ff;
      end
      max_in = csr_we ? csr_data : max_ff;
   end

   // pack results in order of appearance
   always_comb begin
      push          = accept && (a_valid || b_valid);
      push_data.r0  = a_valid ? a_res : b_res;
      push_data.r1  = b_res;
      push_data.two = a_valid && b_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         len_ff  <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         max_ff  <= MAX_RESET;
      end else begin
         pend_ff <= pend_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         max_ff  <= max_in;
      end
   end

endmodule

// ===== rtl/utf8cp_queue.sv =====
// ----------------------------------------------------------------------------
// utf8cp_queue
// Short flip-flop queue between decoder and output sequencer.
// ----------------------------------------------------------------------------
module utf8cp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8cp_pkg::entry_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  nonempty,
   output utf8cp_pkg::entry_type head
);
   import utf8cp_pkg::*;

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign nonempty = cnt_ff != '0;
   assign head     = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/utf8cp_back.sv =====
// ----------------------------------------------------------------------------
// utf8cp_back
// Output sequencer: maps code points to bytes and hands results out one
// per cycle while rsp_pop takes them, through an output register.
// ----------------------------------------------------------------------------
module utf8cp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_nonempty,
   input  utf8cp_pkg::entry_type q_head,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_end,
   output logic [7:0]            rsp_char_count,
   output logic                  rsp_last_of_run
);
   import utf8cp_pkg::*;

   logic       slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic [7:0] count_ff, count_in;
   logic       last_ff, last_in;

   res_type    cur;
   logic       load, last;

   // select the slot and build the next output item
   always_comb begin
      cur      = slot_ff ? q_head.r1 : q_head.r0;
      last     = slot_ff || !q_head.two;
      load     = q_nonempty && (!valid_ff || rsp_pop);
      q_pop    = load && last;
      slot_in  = load ? !last : slot_ff;
      valid_in = load || (valid_ff && !rsp_pop);
      byte_in  = byte_ff;
      end_in   = end_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         byte_in  = cur.is_end ? 8'h00 : map_cp(cur.cp);
         end_in   = cur.is_end;
         count_in = cur.is_end ? cur.count : 8'h00;
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      end_ff   <= end_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_end      = end_ff;
   assign rsp_char_count  = count_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== rtl/utf8_to_cp1251_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp1251_transcoder_unit
// UTF-8 to Windows-1251 transcoder, queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_in_byte and raise req_push; the byte is taken on a
//   clock edge where req_full is low. One byte per cycle is sustained while req_full stays low.
//   Output: while rsp_empty is low the oldest result is on the rsp_ ports;
//   rsp_pop takes it. A byte that completes a character gives one result,
//   a broken sequence followed by a character or a zero byte gives two;
//   rsp_last_of_run marks the final result of a byte. The zero byte gives
//   an end item (rsp_is_end, rsp_char_count) and starts a new string.
//   A byte is decoded into the 4-entry queue at the accepting edge, then
//   the mapping stage puts its result into the output register, from
//   which it can be popped. Results leave at one per cycle while rsp_pop
//   is high, set by the single output register; the two results of a
//   byte leave one after the other.
//   Stall: if rsp_pop stays low the queue fills and req_full rises.
//   csr_max_chars (write through csr_valid/csr_ready, always ready) sets
//   the character limit per string; write it only while idle.
//   Reset (synchronous) empties the queue, clears the decoder and sets the
//   limit to 128.
// ----------------------------------------------------------------------------
module utf8_to_cp1251_transcoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_end,
   output logic [7:0] rsp_char_count,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_chars
);
   import utf8cp_pkg::*;

   logic      accept, q_push, q_pop, q_full, q_nonempty;
   entry_type q_data, q_head;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   utf8cp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_max_chars),
      .push      (q_push),
      .push_data (q_data)
   );

   utf8cp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   utf8cp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_nonempty      (q_nonempty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_end      (rsp_is_end),
      .rsp_char_count  (rsp_char_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // end item is always the last of its byte and carries a zero byte
   a_end_item: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_end) |-> (rsp_last_of_run && rsp_out_byte == 8'h00))
      else $error("end item malformed");

   // character items carry no count
   a_char_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_end) |-> (rsp_char_count == 8'h00))
      else $error("character item with count");

   // never write a full queue, never pop an empty one
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full) && !(q_pop && !q_nonempty))
      else $error("queue overflow or underflow");

   // a queued entry reaches the output register in the next cycle when free
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (q_nonempty && rsp_empty) |=> !rsp_empty)
      else $error("output stage failed to load");

endmodule
